FILE: hw/rtl/fpd_pkg.sv
// ---------------------------------------------------------------------------
// fpd_pkg
// Shared types and codes for the frame deframer.
// ---------------------------------------------------------------------------
`default_nettype none

package fpd_pkg;

  // Result event codes
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_PAYLOAD = 3'd1;
  localparam logic [2:0] EV_GOOD    = 3'd2;
  localparam logic [2:0] EV_BADSUM  = 3'd3;
  localparam logic [2:0] EV_TOOLONG = 3'd4;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_MAX_LEN     = 2'd2;

  localparam logic [7:0]  SYNC_FIRST_RST  = 8'd147;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'd224;
  localparam logic [15:0] MAX_LEN_RST     = 16'd1017;

  // Type byte, two length bytes and two sync bytes ahead of the payload
  localparam logic [16:0] HEADER_BYTES = 17'd5;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_payload_length;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  data_byte;
    logic [7:0]  packet_type;
    logic [15:0] payload_length;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fpd_cfg_regs.sv
// ---------------------------------------------------------------------------
// fpd_cfg_regs
// APB-style register file: sync values and payload length limit.
// ---------------------------------------------------------------------------
`default_nettype none

module fpd_cfg_regs
  import fpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic       wr_en;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign wr_en     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first         <= SYNC_FIRST_RST;
      cfg.sync_second        <= SYNC_SECOND_RST;
      cfg.max_payload_length <= MAX_LEN_RST;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_SYNC_FIRST:  cfg.sync_first         <= pwdata[7:0];
        REG_SYNC_SECOND: cfg.sync_second        <= pwdata[7:0];
        REG_MAX_LEN:     cfg.max_payload_length <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_SYNC_FIRST:  prdata = {24'd0, cfg.sync_first};
      REG_SYNC_SECOND: prdata = {24'd0, cfg.sync_second};
      REG_MAX_LEN:     prdata = {16'd0, cfg.max_payload_length};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fpd_parser.sv
// ---------------------------------------------------------------------------
// fpd_parser
// Frame position tracking, running Fletcher sums and verdict per byte.
// ---------------------------------------------------------------------------
`default_nettype none

module fpd_parser
  import fpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  input  wire cfg_t       cfg,
  output result_t         res
);

  logic [16:0] frame_position, frame_position_next;
  logic [15:0] frame_length, frame_length_next;
  logic [7:0]  frame_type, frame_type_next;
  logic [7:0]  sum_first, sum_first_next;
  logic [7:0]  sum_second, sum_second_next;

  logic [16:0] check_a;
  logic [7:0]  acc_a, acc_b;
  logic [15:0] len_full;
  logic        clear;

  assign check_a  = {1'b0, frame_length} + HEADER_BYTES;
  assign acc_a    = sum_first + rx_byte;
  assign acc_b    = sum_second + acc_a;
  assign len_full = {rx_byte, frame_length[7:0]};

  always_comb begin
    frame_position_next = frame_position;
    frame_length_next   = frame_length;
    frame_type_next     = frame_type;
    sum_first_next      = sum_first;
    sum_second_next     = sum_second;
    res.event_res       = EV_NONE;
    res.data_byte       = 8'd0;
    clear               = 1'b0;

    priority if (frame_position == 17'd0) begin
      if (rx_byte == cfg.sync_first) begin
        sum_first_next      = acc_a;
        sum_second_next     = acc_b;
        frame_position_next = 17'd1;
      end
    end else if (frame_position == 17'd1) begin
      // a bad second sync byte waits here, no fallback to the first
      if (rx_byte == cfg.sync_second) begin
        sum_first_next      = acc_a;
        sum_second_next     = acc_b;
        frame_position_next = 17'd2;
      end
    end else if (frame_position == 17'd2) begin
      frame_type_next     = rx_byte;
      sum_first_next      = acc_a;
      sum_second_next     = acc_b;
      frame_position_next = 17'd3;
    end else if (frame_position == 17'd3) begin
      frame_length_next   = {8'd0, rx_byte};
      sum_first_next      = acc_a;
      sum_second_next     = acc_b;
      frame_position_next = 17'd4;
    end else if (frame_position == 17'd4) begin
      frame_length_next = len_full;
      if (len_full > cfg.max_payload_length) begin
        res.event_res = EV_TOOLONG;
        clear         = 1'b1;
      end else begin
        sum_first_next      = acc_a;
        sum_second_next     = acc_b;
        frame_position_next = 17'd5;
      end
    end else if (frame_position < check_a) begin
      res.event_res       = EV_PAYLOAD;
      res.data_byte       = rx_byte;
      sum_first_next      = acc_a;
      sum_second_next     = acc_b;
      frame_position_next = frame_position + 17'd1;
    end else if (frame_position == check_a) begin
      if (rx_byte == sum_first) begin
        frame_position_next = frame_position + 17'd1;
      end else begin
        res.event_res = EV_BADSUM;
        clear         = 1'b1;
      end
    end else if (frame_position == check_a + 17'd1) begin
      res.event_res = (rx_byte == sum_second) ? EV_GOOD : EV_BADSUM;
      clear         = 1'b1;
    end else begin
      // position out of range: drop the frame quietly
      clear           = 1'b1;
      frame_type_next   = 8'd0;
      frame_length_next = 16'd0;
    end

    // type and length as seen after this byte, before any clear
    res.packet_type    = frame_type_next;
    res.payload_length = frame_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= 17'd0;
      frame_length   <= 16'd0;
      frame_type     <= 8'd0;
      sum_first      <= 8'd0;
      sum_second     <= 8'd0;
    end else if (accept) begin
      if (clear) begin
        frame_position <= 17'd0;
        frame_length   <= 16'd0;
        frame_type     <= 8'd0;
        sum_first      <= 8'd0;
        sum_second     <= 8'd0;
      end else begin
        frame_position <= frame_position_next;
        frame_length   <= frame_length_next;
        frame_type     <= frame_type_next;
        sum_first      <= sum_first_next;
        sum_second     <= sum_second_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    frame_position <= check_a + 17'd1)
    else $error("frame position beyond second check byte");

  a_len_limit: assert property (@(posedge clk) disable iff (rst)
    (accept && frame_position == 17'd4 && !clear) |=>
      (frame_length <= $past(cfg.max_payload_length)))
    else $error("payload length accepted above limit");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/fpd_out_buf.sv
// ---------------------------------------------------------------------------
// fpd_out_buf
// Two-entry result buffer: output register plus skid entry.
// ---------------------------------------------------------------------------
`default_nettype none

module fpd_out_buf
  import fpd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         full,
  output logic         head_valid,
  output result_t      head,
  input  wire logic    pop
);

  logic [1:0] count;
  result_t    skid;
  logic       do_pop;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign do_pop     = pop & head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      unique case ({push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case ({push, do_pop})
      2'b10: begin
        if (count == 2'd0) head <= push_data;
        else               skid <= push_data;
      end
      2'b01: head <= skid;
      2'b11: begin
        if (count == 2'd1) begin
          head <= push_data;
        end else begin
          head <= skid;
          skid <= push_data;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full result buffer");

  a_head_hold: assert property (@(posedge clk) disable iff (rst)
    (head_valid && !pop) |=> (head == $past(head)))
    else $error("unpopped head item changed");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/fletcher8_packet_deframer.sv
// ---------------------------------------------------------------------------
// fletcher8_packet_deframer
// Byte-stream deframer with Fletcher-8 check, cut-through payload output.
// ---------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------
//  input   | in_valid / in_stall   | rx_byte
//  output  | out_valid / out_stall | event_res, data_byte, packet_type,
//          |                       | payload_length
//  config  | APB psel/penable      | paddr, pwdata, prdata
//
//  One item in, one result out; one byte per cycle sustained while out_stall
//  is low. The parser state (position counter and running sums) updates in
//  the cycle the byte is taken, and the result lands in a two-entry output
//  buffer. First result appears the cycle after acceptance.
//  in_stall rises only when both buffer entries hold untaken results.
//  rst is synchronous: clears parser state and buffer, reloads registers.
// ---------------------------------------------------------------------------
`default_nettype none

module fletcher8_packet_deframer
  import fpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // byte input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  // result output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       event_res,
  output logic [7:0]       data_byte,
  output logic [7:0]       packet_type,
  output logic [15:0]      payload_length,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t    cfg;
  result_t step_res;
  result_t head;
  logic    buf_full;
  logic    in_accept;

  assign in_stall  = buf_full;
  assign in_accept = in_valid & ~in_stall;

  fpd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // per-byte parse step; state moves only on an accepted item
  fpd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (in_accept),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .res     (step_res)
  );

  // output register with skid entry
  fpd_out_buf u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (in_accept),
    .push_data  (step_res),
    .full       (buf_full),
    .head_valid (out_valid),
    .head       (head),
    .pop        (~out_stall)
  );

  assign event_res      = head.event_res;
  assign data_byte      = head.data_byte;
  assign packet_type    = head.packet_type;
  assign payload_length = head.payload_length;

`ifndef SYNTHESIS
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res != EV_PAYLOAD) |-> (data_byte == 8'd0))
    else $error("data byte set on non-payload item");

  a_event_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_res <= EV_TOOLONG))
    else $error("event code out of range");
`endif

endmodule

`default_nettype wire

FILE: verif/fletcher8_packet_deframer_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// fletcher8_packet_deframer_tb
// Self-checking bench for the frame deframer: a short table of directed
// bytes, then random frames (good, bad checks, too long, cut short, with
// line noise) under several register settings, random idle on both sides
// and one long output hold-off. Every result is checked against a pinned
// value from the directed table or an in-bench parser model.
// ---------------------------------------------------------------------------

module fletcher8_packet_deframer_tb;
  import fpd_pkg::*;

  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 20;
  // long receiver hold-off, started once after this many results
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 80;

  // parser positions ahead of the payload
  localparam logic [16:0] AT_SYNC_FIRST  = 17'd0;
  localparam logic [16:0] AT_SYNC_SECOND = 17'd1;
  localparam logic [16:0] AT_TYPE        = 17'd2;
  localparam logic [16:0] AT_LEN_LOW     = 17'd3;
  localparam logic [16:0] AT_LEN_HIGH    = 17'd4;

  // one directed item; pinned rows carry a hand-written result
  typedef struct packed {
    logic [7:0] rx;
    logic       pinned;
    result_t    want;
  } stim_row_t;

  // Directed table, reset register values (sync 0x93 0xE0, limit 1017).
  //  frame 1: noise and a bad second sync byte, type 0xFF, zero length, good
  //  frame 2: type 0x00, one payload byte 0xFF, second check byte wrong
  //  frame 3: type 0xA5, length 0xFFFF, aborted as too long
  localparam stim_row_t DIRECTED [22] = '{
    '{8'h00,           1'b1, '{EV_NONE,    8'h00, 8'h00, 16'h0000}},
    '{SYNC_FIRST_RST,  1'b1, '{EV_NONE,    8'h00, 8'h00, 16'h0000}},
    '{8'hFF,           1'b1, '{EV_NONE,    8'h00, 8'h00, 16'h0000}},
    '{SYNC_SECOND_RST, 1'b1, '{EV_NONE,    8'h00, 8'h00, 16'h0000}},
    '{8'hFF,           1'b1, '{EV_NONE,    8'h00, 8'hFF, 16'h0000}},
    '{8'h00,           1'b1, '{EV_NONE,    8'h00, 8'hFF, 16'h0000}},
    '{8'h00,           1'b1, '{EV_NONE,    8'h00, 8'hFF, 16'h0000}},
    '{8'h72,           1'b0, '0},
    '{8'h5C,           1'b0, '0},
    '{SYNC_FIRST_RST,  1'b1, '{EV_NONE,    8'h00, 8'h00, 16'h0000}},
    '{SYNC_SECOND_RST, 1'b1, '{EV_NONE,    8'h00, 8'h00, 16'h0000}},
    '{8'h00,           1'b1, '{EV_NONE,    8'h00, 8'h00, 16'h0000}},
    '{8'h01,           1'b1, '{EV_NONE,    8'h00, 8'h00, 16'h0001}},
    '{8'h00,           1'b1, '{EV_NONE,    8'h00, 8'h00, 16'h0001}},
    '{8'hFF,           1'b1, '{EV_PAYLOAD, 8'hFF, 8'h00, 16'h0001}},
    '{8'h73,           1'b0, '0},
    '{8'h00,           1'b1, '{EV_BADSUM,  8'h00, 8'h00, 16'h0001}},
    '{SYNC_FIRST_RST,  1'b1, '{EV_NONE,    8'h00, 8'h00, 16'h0000}},
    '{SYNC_SECOND_RST, 1'b1, '{EV_NONE,    8'h00, 8'h00, 16'h0000}},
    '{8'hA5,           1'b1, '{EV_NONE,    8'h00, 8'hA5, 16'h0000}},
    '{8'hFF,           1'b1, '{EV_NONE,    8'h00, 8'hA5, 16'h00FF}},
    '{8'hFF,           1'b1, '{EV_TOOLONG, 8'h00, 8'hA5, 16'hFFFF}}
  };

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte  = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  event_res;
  logic [7:0]  data_byte;
  logic [7:0]  packet_type;
  logic [15:0] payload_length;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = 4'h0;
  logic [31:0] pwdata   = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  fletcher8_packet_deframer dut (.*);

  always #5 clk = ~clk;

  // Parser model: register copy, frame position, header fields, running sums
  cfg_t        cur_cfg;
  logic [16:0] parse_pos;
  logic [15:0] parse_len;
  logic [7:0]  parse_type;
  logic [7:0]  sum_a;
  logic [7:0]  sum_b;

  result_t     frame_events_due [$];  // results owed by the block, oldest first
  int unsigned bytes_sent;
  int unsigned results_taken;
  int unsigned bad_count;
  bit          tx_burst;
  bit          rx_burst;

  function automatic void fold_sum(input logic [7:0] b);
    sum_a = sum_a + b;
    sum_b = sum_b + sum_a;
  endfunction

  function automatic void drop_frame();
    parse_pos  = '0;
    parse_len  = '0;
    parse_type = '0;
    sum_a      = '0;
    sum_b      = '0;
  endfunction

  // Advance the parser model by one byte and return the result it owes.
  function automatic result_t deframe_byte(input logic [7:0] b);
    result_t     r;
    logic        done;
    logic [16:0] check_pos;
    r         = '0;
    done      = 1'b0;
    check_pos = {1'b0, parse_len} + HEADER_BYTES;
    if (parse_pos == AT_SYNC_FIRST) begin
      // mismatching sync bytes are dropped without moving
      if (b == cur_cfg.sync_first) begin
        fold_sum(b);
        parse_pos = AT_SYNC_SECOND;
      end
    end else if (parse_pos == AT_SYNC_SECOND) begin
      if (b == cur_cfg.sync_second) begin
        fold_sum(b);
        parse_pos = AT_TYPE;
      end
    end else if (parse_pos == AT_TYPE) begin
      parse_type = b;
      fold_sum(b);
      parse_pos = AT_LEN_LOW;
    end else if (parse_pos == AT_LEN_LOW) begin
      parse_len = {8'h00, b};
      fold_sum(b);
      parse_pos = AT_LEN_HIGH;
    end else if (parse_pos == AT_LEN_HIGH) begin
      // limit is sampled here, not at frame start
      parse_len[15:8] = b;
      if (parse_len > cur_cfg.max_payload_length) begin
        r.event_res = EV_TOOLONG;
        done = 1'b1;
      end else begin
        fold_sum(b);
        parse_pos = HEADER_BYTES;
      end
    end else if (parse_pos < check_pos) begin
      r.event_res = EV_PAYLOAD;
      r.data_byte = b;
      fold_sum(b);
      parse_pos = parse_pos + 17'd1;
    end else if (parse_pos == check_pos) begin
      if (b == sum_a) begin
        parse_pos = parse_pos + 17'd1;
      end else begin
        r.event_res = EV_BADSUM;
        done = 1'b1;
      end
    end else if (parse_pos == check_pos + 17'd1) begin
      r.event_res = (b == sum_b) ? EV_GOOD : EV_BADSUM;
      done = 1'b1;
    end else begin
      drop_frame();
    end
    r.packet_type    = parse_type;
    r.payload_length = parse_len;
    if (done) drop_frame();
    return r;
  endfunction

  function automatic void note_failure(input string msg);
    if (bad_count < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    bad_count++;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] got,
                                      input logic [15:0] want);
    if (got !== want)
      note_failure($sformatf("result %0d %s: expected 0x%0h, got 0x%0h",
                             results_taken, name, want, got));
  endfunction

  // Offer one item after a random gap and hold it until taken. Valid stays
  // high across back-to-back items so it never toggles within one step.
  task automatic push_byte(input logic [7:0] b, input bit pinned = 1'b0,
                           input result_t pinned_res = '0);
    int unsigned gap;
    result_t     r;
    if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = deframe_byte(b);
    frame_events_due.push_back(pinned ? pinned_res : r);
    bytes_sent++;
  endtask

  // Build one frame under the current settings, sometimes damaged, and send it.
  task automatic send_random_frame();
    logic [7:0]  body [$];
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  junk;
    logic [15:0] len;
    int unsigned pick;
    int unsigned flaw;
    int unsigned lim;
    lim  = 32'(cur_cfg.max_payload_length);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      len = 16'($urandom_range(0, 8));
    end else if (pick < 78) begin
      len = 16'($urandom_range(9, 40));
    end else if (pick < 86 && lim <= 64) begin
      len = 16'(lim);                         // right at the limit
    end else if (pick >= 86 && lim < 65535) begin
      len = 16'(lim + 1 + $urandom_range(0, 65534 - lim));
    end else begin
      len = 16'($urandom_range(0, 8));
    end

    body.push_back(cur_cfg.sync_first);
    body.push_back(cur_cfg.sync_second);
    body.push_back(8'($urandom));
    body.push_back(len[7:0]);
    body.push_back(len[15:8]);
    if (len <= lim) begin
      repeat (len) body.push_back(8'($urandom));
      a = 8'h00;
      b = 8'h00;
      foreach (body[i]) begin
        a = a + body[i];
        b = b + a;
      end
      body.push_back(a);
      body.push_back(b);
    end

    flaw = $urandom_range(0, 99);
    if (flaw < 60) begin
      // well formed
    end else if (flaw < 68 && len <= lim) begin
      body[body.size() - 2] ^= 8'($urandom_range(1, 255));
    end else if (flaw < 76 && len <= lim) begin
      body[body.size() - 1] ^= 8'($urandom_range(1, 255));
    end else if (flaw < 84) begin
      // cut short; the leftovers land in whatever comes next
      repeat ($urandom_range(1, body.size() - 1)) void'(body.pop_back());
    end else if (flaw < 92) begin
      repeat ($urandom_range(1, 4)) begin
        do junk = 8'($urandom); while (junk == cur_cfg.sync_first);
        body.push_front(junk);
      end
    end else begin
      // wrong second sync bytes: ignored, parser stays on that position
      repeat ($urandom_range(1, 3)) begin
        do junk = 8'($urandom); while (junk == cur_cfg.sync_second);
        body.insert(1, junk);
      end
    end
    foreach (body[i]) push_byte(body[i]);
  endtask

  task automatic send_random_frames(input int unsigned n_bytes);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) send_random_frame();
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (frame_events_due.size() != 0) @(posedge clk);
  endtask

  // One APB setup + access; psel stays up so writes can run back to back.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic program_cfg(input logic [7:0] s1, input logic [7:0] s2,
                             input logic [15:0] lim);
    write_reg(REG_SYNC_FIRST,  {24'h0, s1});
    write_reg(REG_SYNC_SECOND, {24'h0, s2});
    write_reg(REG_MAX_LEN,     {16'h0, lim});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_cfg = '{s1, s2, lim};
  endtask

  // Byte side: reset, directed table, then four random phases.
  initial begin : byte_side
    cur_cfg = '{SYNC_FIRST_RST, SYNC_SECOND_RST, MAX_LEN_RST};
    drop_frame();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) push_byte(DIRECTED[i].rx, DIRECTED[i].pinned, DIRECTED[i].want);
    send_random_frames(220);

    // Leave a header open across the register change: the second sync byte
    // and the length limit of the new setting apply to this frame.
    push_byte(cur_cfg.sync_first);
    settle();
    program_cfg(8'h00, 8'hFF, 16'hFFFF);
    push_byte(cur_cfg.sync_second);
    push_byte(8'($urandom));
    push_byte(8'h10);
    send_random_frames(220);

    settle();
    program_cfg(8'hFF, 8'h00, 16'h0000);     // only empty frames fit
    send_random_frames(150);

    settle();
    program_cfg(8'($urandom), 8'($urandom), 16'($urandom_range(0, 24)));
    send_random_frames(260);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_count == 0 && frame_events_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result side: random stall per item, one long hold-off so the output
  // buffer fills and the block pushes back on its input.
  initial begin : result_side
    int unsigned hold;
    result_t     want;
    wait (rst == 1'b0);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
      hold = rx_burst ? 0 : $urandom_range(0, 14);
      if (results_taken == HOLD_AT) hold = HOLD_CYCLES;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_taken++;
      if (frame_events_due.size() == 0) begin
        note_failure($sformatf("result %0d arrived with none owed (event %0d)",
                               results_taken, event_res));
      end else begin
        want = frame_events_due.pop_front();
        check_field("event_res",      16'(event_res),   16'(want.event_res));
        check_field("data_byte",      16'(data_byte),   16'(want.data_byte));
        check_field("packet_type",    16'(packet_type), 16'(want.packet_type));
        check_field("payload_length", payload_length,   want.payload_length);
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/fpd_pkg.sv
hw/rtl/fpd_cfg_regs.sv
hw/rtl/fpd_parser.sv
hw/rtl/fpd_out_buf.sv
hw/rtl/fletcher8_packet_deframer.sv
verif/fletcher8_packet_deframer_tb.sv
